@@ design/frame_rms_auto_gain_macros.svh @@
// ----------------------------------------------------------------------------
// frame_rms_auto_gain_macros
// Assertion helpers used by frame_rms_auto_gain.
// ----------------------------------------------------------------------------
`ifndef FRAME_RMS_AUTO_GAIN_MACROS_SVH
`define FRAME_RMS_AUTO_GAIN_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define FRAG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under an active-low reset.
`define FRAG_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/frag_pkg.sv @@
// ----------------------------------------------------------------------------
// frag_pkg
// Shared widths, constants, register indexes and unit status type.
// ----------------------------------------------------------------------------
package frag_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int GAIN_W            = 24;
  localparam int RATE_W            = 17;
  localparam int LEVEL_W           = 15;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 24;
  localparam int FRAME_SAMPLES_DEF = 160;
  localparam int MUL_A_W           = 24;
  localparam int MUL_B_W           = 17;

  localparam logic [GAIN_W-1:0] GAIN_ONE          = 24'd65536;
  localparam logic [GAIN_W-1:0] GAIN_NEAR_ONE_MAX = 24'd65601;
  localparam logic [RATE_W-1:0] RATE_ONE          = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_ENABLE  = 3'd0,
    REG_TARGET_LEVEL = 3'd1,
    REG_GAIN_CEILING = 3'd2,
    REG_RISE_RATE    = 3'd3,
    REG_FALL_RATE    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ design/frag_if.sv @@
// ----------------------------------------------------------------------------
// frag_if
// Handshake channels: sample input, result output, register write.
// ----------------------------------------------------------------------------
interface frag_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [frag_pkg::SAMPLE_W-1:0] in_sample;
  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface frag_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [frag_pkg::SAMPLE_W-1:0] out_sample;
  logic [frag_pkg::GAIN_W-1:0]          applied_gain;
  modport source (output valid, output out_sample, output applied_gain, input ready);
  modport sink   (input valid, input out_sample, input applied_gain, output ready);
endinterface

interface frag_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [frag_pkg::CFG_IDX_W-1:0]    index;
  logic [frag_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/frag_smul.sv @@
// ----------------------------------------------------------------------------
// frag_smul
// Bit-serial unsigned multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module frag_smul #(
  parameter int AW = frag_pkg::MUL_A_W,
  parameter int BW = frag_pkg::MUL_B_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [AW-1:0]       mcand_i,
  input  logic [BW-1:0]       mplier_i,
  output frag_pkg::unit_sts_t sts_o,
  output logic [AW+BW-1:0]    prod_o
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] acc_q;
  logic [AW-1:0] mcand_q;
  logic [BW-1:0] mplier_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
    end else if (busy_q) begin
      // shift in one partial product per cycle
      acc_q    <= {acc_q[PW-2:0], 1'b0} + (mplier_q[BW-1] ? PW'(mcand_q) : '0);
      mplier_q <= {mplier_q[BW-2:0], 1'b0};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign prod_o     = acc_q;

endmodule

@@ design/frag_sdiv.sv @@
// ----------------------------------------------------------------------------
// frag_sdiv
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frag_sdiv #(
  parameter int DW = 54,
  parameter int VW = 27
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DW-1:0]       dividend_i,
  input  logic [VW-1:0]       divisor_i,
  output frag_pkg::unit_sts_t sts_o,
  output logic [DW-1:0]       quot_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? VW'(trial - {1'b0, div_q}) : trial[VW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = quo_q;

endmodule

@@ design/frag_isqrt.sv @@
// ----------------------------------------------------------------------------
// frag_isqrt
// Integer square root, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module frag_isqrt #(
  parameter int RW = 54
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [RW-1:0]       rad_i,
  output frag_pkg::unit_sts_t sts_o,
  output logic [RW/2-1:0]     root_o
);

  localparam int HW = RW / 2;
  localparam int CW = $clog2(HW + 1);

  logic [RW-1:0]   rad_q;
  logic [HW+1:0]   rem_q;
  logic [HW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q;
  logic [HW+2:0]   part;
  logic [HW+2:0]   trial;
  logic            fits;

  assign part  = {rem_q[HW:0], rad_q[RW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign fits  = part >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(HW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? (HW+2)'(part - trial) : part[HW+1:0];
      root_q <= {root_q[HW-2:0], fits};
      rad_q  <= {rad_q[RW-3:0], 2'b00};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = root_q;

endmodule

@@ design/frame_rms_auto_gain.sv @@
// ----------------------------------------------------------------------------
// frame_rms_auto_gain
// Frame-based RMS automatic gain control for 16-bit audio samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one signed sample per word; out_if returns one word per
//   sample: the sample at the same frame position one frame earlier, scaled
//   by the running Q8.16 gain, rounded half away from zero and saturated,
//   together with the gain applied to it (65536 on pass-through).
//   cfg_if writes the five registers by index; it is always ready, and is
//   meant to be written only while no sample is in flight.
//   A new sample is taken only once the last one and any frame-end math
//   are done. Applying the gain takes two runs of the shared bit-serial
//   multiplier (energy square, then gain apply); pass-through takes one.
//   The last sample of an enabled frame adds the /N divide, square root,
//   target divide and smoothing multiply, all serial; the target divide
//   is skipped when the level is at or below one.
//   Reset clears index and energy, sets gain to one, registers to defaults;
//   the delay store is not cleared but reads as zero during the first frame.
//   A stalled receiver holds the result word in the output register; the
//   next sample is taken meanwhile and waits for that register to drain.
// ----------------------------------------------------------------------------
`include "frame_rms_auto_gain_macros.svh"

module frame_rms_auto_gain #(
  parameter int FRAME_SAMPLES = frag_pkg::FRAME_SAMPLES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  frag_in_if.sink    in_if,
  frag_out_if.source out_if,
  frag_cfg_if.sink   cfg_if
);

  localparam int SW    = frag_pkg::SAMPLE_W;
  localparam int GW    = frag_pkg::GAIN_W;
  localparam int RTW   = frag_pkg::RATE_W;
  localparam int LW    = frag_pkg::LEVEL_W;
  localparam int MAW   = frag_pkg::MUL_A_W;
  localparam int MBW   = frag_pkg::MUL_B_W;
  localparam int PW    = MAW + MBW;
  localparam int IDX_W = $clog2(FRAME_SAMPLES);
  localparam int NW    = $clog2(FRAME_SAMPLES + 1);
  localparam int EW    = 30 + NW;
  localparam int QW    = EW + 16;
  localparam int RW    = QW + (QW % 2);
  localparam int HW    = RW / 2;
  localparam int TW    = LW + GW;
  localparam int DW    = (RW > TW) ? RW : TW;
  localparam int VW    = (NW > HW) ? NW : HW;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_MUL_E, S_MUL_G, S_OUT,
    S_DIV_N, S_SQRT, S_DIV_T, S_PREP, S_MUL_S
  } state_e;

  // registers
  logic           enable_q;
  logic [LW-1:0]  target_q;
  logic [GW-1:0]  ceiling_q;
  logic [RTW-1:0] rise_q, fall_q;

  state_e           state_q;
  logic [IDX_W-1:0] idx_q;
  logic             seen_q, zero_q, last_q;
  logic [EW-1:0]    energy_q;
  logic [GW-1:0]    gain_q, desired_q;
  logic [SW-1:0]    new_q, rd_q, res_q;
  logic             gained_q, up_q;
  logic             ovalid_q;
  logic [SW-1:0]    osample_q;
  logic [GW-1:0]    ogain_q;

  logic [SW-1:0] store_q [FRAME_SAMPLES];

  logic            mul_go_q, div_go_q, sqrt_go_q;
  logic [MAW-1:0]  mul_a_q;
  logic [MBW-1:0]  mul_b_q;
  logic [DW-1:0]   div_a_q;
  logic [VW-1:0]   div_b_q;
  logic [RW-1:0]   rad_q;

  frag_pkg::unit_sts_t mul_sts, div_sts, sqrt_sts;
  logic [PW-1:0]   mul_p;
  logic [DW-1:0]   div_quo;
  logic [HW-1:0]   root;

  logic            in_acc;
  logic            out_fire;
  logic            apply_gain;
  logic [SW-1:0]   old_s, new_s;
  logic [MBW-1:0]  old_mag, new_mag;
  logic [GW-1:0]   ceil_eff;
  logic [LW-1:0]   target_eff;
  logic [PW-1:0]   rsum;
  logic [PW-17:0]  rq;
  logic [SW-1:0]   sat_res;
  logic [GW-1:0]   des_clamp;
  logic [RTW-1:0]  rate_eff;
  logic [GW-1:0]   diff;
  logic [GW+1:0]   gnext, gclamp;

  assign in_acc       = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_q == S_IDLE);
  assign cfg_if.ready = 1'b1;

  // output register is free to load
  assign out_fire   = !ovalid_q || out_if.ready;
  assign apply_gain = enable_q && (gain_q > frag_pkg::GAIN_NEAR_ONE_MAX);

  assign out_if.valid        = ovalid_q;
  assign out_if.out_sample   = osample_q;
  assign out_if.applied_gain = ogain_q;

  // first frame reads zeros from the store
  assign old_s   = zero_q ? '0 : rd_q;
  assign new_s   = new_q;
  assign old_mag = old_s[SW-1] ? (MBW'(0) - {old_s[SW-1], old_s}) : {1'b0, old_s};
  assign new_mag = new_s[SW-1] ? (MBW'(0) - {new_s[SW-1], new_s}) : {1'b0, new_s};

  assign ceil_eff   = (ceiling_q < frag_pkg::GAIN_ONE) ? frag_pkg::GAIN_ONE : ceiling_q;
  assign target_eff = (target_q == '0) ? LW'(1) : target_q;

  // round half up on a Q.16 product
  assign rsum = mul_p + PW'(32768);
  assign rq   = rsum[PW-1:16];

  always_comb begin
    if (old_s[SW-1]) begin
      sat_res = (rq > (PW-16)'(32768)) ? 16'h8000 : (SW'(0) - rq[SW-1:0]);
    end else begin
      sat_res = (rq > (PW-16)'(32767)) ? 16'h7FFF : rq[SW-1:0];
    end
  end

  always_comb begin
    if (div_quo > DW'(ceil_eff)) begin
      des_clamp = ceil_eff;
    end else if (div_quo < DW'(frag_pkg::GAIN_ONE)) begin
      des_clamp = frag_pkg::GAIN_ONE;
    end else begin
      des_clamp = div_quo[GW-1:0];
    end
  end

  always_comb begin
    rate_eff = (desired_q > gain_q) ? rise_q : fall_q;
    if (rate_eff > frag_pkg::RATE_ONE) begin
      rate_eff = frag_pkg::RATE_ONE;
    end
    diff = (desired_q >= gain_q) ? (desired_q - gain_q) : (gain_q - desired_q);
  end

  always_comb begin
    if (up_q) begin
      gnext = (GW+2)'(gain_q) + (GW+2)'(rq);
    end else if ((PW-16)'(gain_q) <= rq) begin
      gnext = '0;
    end else begin
      gnext = (GW+2)'(gain_q) - (GW+2)'(rq);
    end
    if (gnext > (GW+2)'(ceil_eff)) begin
      gclamp = (GW+2)'(ceil_eff);
    end else if (gnext < (GW+2)'(frag_pkg::GAIN_ONE)) begin
      gclamp = (GW+2)'(frag_pkg::GAIN_ONE);
    end else begin
      gclamp = gnext;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      target_q  <= LW'(3000);
      ceiling_q <= GW'(262144);
      rise_q    <= RTW'(6554);
      fall_q    <= RTW'(6554);
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        frag_pkg::REG_GAIN_ENABLE:  enable_q  <= cfg_if.data[0];
        frag_pkg::REG_TARGET_LEVEL: target_q  <= cfg_if.data[LW-1:0];
        frag_pkg::REG_GAIN_CEILING: ceiling_q <= cfg_if.data[GW-1:0];
        frag_pkg::REG_RISE_RATE:    rise_q    <= cfg_if.data[RTW-1:0];
        frag_pkg::REG_FALL_RATE:    fall_q    <= cfg_if.data[RTW-1:0];
        default: ;
      endcase
    end
  end

  // delay store: read old word and write new one at the same address
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q           <= store_q[idx_q];
      store_q[idx_q] <= in_if.in_sample;
      new_q          <= in_if.in_sample;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      seen_q    <= 1'b0;
      zero_q    <= 1'b1;
      last_q    <= 1'b0;
      energy_q  <= '0;
      gain_q    <= frag_pkg::GAIN_ONE;
      ovalid_q  <= 1'b0;
      mul_go_q  <= 1'b0;
      div_go_q  <= 1'b0;
      sqrt_go_q <= 1'b0;
    end else begin
      // start pulses for the serial units
      mul_go_q  <= (state_q == S_READ) || (state_q == S_PREP) ||
                   ((state_q == S_MUL_E) && mul_sts.done && apply_gain);
      div_go_q  <= ((state_q == S_OUT) && out_fire && last_q && enable_q) ||
                   ((state_q == S_SQRT) && sqrt_sts.done && (root > HW'(256)));
      sqrt_go_q <= (state_q == S_DIV_N) && div_sts.done;
      if ((state_q == S_OUT) && out_fire) begin
        ovalid_q <= 1'b1;
      end else if (out_if.valid && out_if.ready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            zero_q <= !seen_q;
            if (idx_q == IDX_W'(FRAME_SAMPLES - 1)) begin
              last_q <= 1'b1;
              idx_q  <= '0;
              seen_q <= 1'b1;
            end else begin
              last_q <= 1'b0;
              idx_q  <= idx_q + 1'b1;
            end
            state_q <= S_READ;
          end
        end
        S_READ: begin
          mul_a_q  <= MAW'(new_mag);
          mul_b_q  <= new_mag;
          state_q  <= S_MUL_E;
        end
        S_MUL_E: begin
          if (mul_sts.done) begin
            energy_q <= energy_q + EW'(mul_p[31:0]);
            if (apply_gain) begin
              mul_a_q  <= gain_q;
              mul_b_q  <= old_mag;
              gained_q <= 1'b1;
              state_q  <= S_MUL_G;
            end else begin
              res_q    <= old_s;
              gained_q <= 1'b0;
              state_q  <= S_OUT;
            end
          end
        end
        S_MUL_G: begin
          if (mul_sts.done) begin
            res_q   <= sat_res;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            osample_q <= res_q;
            ogain_q   <= gained_q ? gain_q : frag_pkg::GAIN_ONE;
            if (last_q) begin
              energy_q <= '0;
            end
            if (last_q && enable_q) begin
              div_a_q  <= DW'({energy_q, 16'd0});
              div_b_q  <= VW'(FRAME_SAMPLES);
              state_q  <= S_DIV_N;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_DIV_N: begin
          if (div_sts.done) begin
            rad_q     <= div_quo[RW-1:0];
            state_q   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_sts.done) begin
            if (root > HW'(256)) begin
              div_a_q  <= DW'({target_eff, 24'd0});
              div_b_q  <= VW'(root);
              state_q  <= S_DIV_T;
            end else begin
              desired_q <= ceil_eff;
              state_q   <= S_PREP;
            end
          end
        end
        S_DIV_T: begin
          if (div_sts.done) begin
            desired_q <= des_clamp;
            state_q   <= S_PREP;
          end
        end
        S_PREP: begin
          up_q     <= desired_q >= gain_q;
          mul_a_q  <= diff;
          mul_b_q  <= rate_eff;
          state_q  <= S_MUL_S;
        end
        S_MUL_S: begin
          if (mul_sts.done) begin
            gain_q  <= gclamp[GW-1:0];
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  frag_smul #(.AW(MAW), .BW(MBW)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_go_q),
    .mcand_i  (mul_a_q),
    .mplier_i (mul_b_q),
    .sts_o    (mul_sts),
    .prod_o   (mul_p)
  );

  frag_sdiv #(.DW(DW), .VW(VW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .sts_o      (div_sts),
    .quot_o     (div_quo)
  );

  frag_isqrt #(.RW(RW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_go_q),
    .rad_i   (rad_q),
    .sts_o   (sqrt_sts),
    .root_o  (root)
  );

  `FRAG_ASSERT_NXT(a_one_item, clk_i, rst_ni, in_acc, !in_if.ready, "second word taken")
  `FRAG_ASSERT_IMP(a_gain_floor, clk_i, rst_ni, 1'b1, gain_q >= frag_pkg::GAIN_ONE, "gain below one")
  `FRAG_ASSERT_IMP(a_mul_free, clk_i, rst_ni, mul_go_q, !mul_sts.busy, "multiplier restarted busy")
  `FRAG_ASSERT_IMP(a_div_free, clk_i, rst_ni, div_go_q, !div_sts.busy, "divider restarted busy")

endmodule

@@ tb/frag_tb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frag_tb_if
// Testbench types; the channel interfaces come from the design's frag_if.sv.
// ----------------------------------------------------------------------------
package frag_tb_pkg;

  // One result word as seen on the output channel.
  typedef struct packed {
    logic signed [frag_pkg::SAMPLE_W-1:0] out_sample;
    logic [frag_pkg::GAIN_W-1:0]          applied_gain;
  } agc_word_t;
endpackage

@@ tb/frame_rms_auto_gain_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rms_auto_gain_test
// Drives samples through the RMS gain control under several register settings
// and idling patterns, predicts every result word and compares field by field.
// ----------------------------------------------------------------------------
module frame_rms_auto_gain_test;

  localparam int NFRAME = frag_pkg::FRAME_SAMPLES_DEF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  frag_in_if  in_if ();
  frag_out_if out_if ();
  frag_cfg_if cfg_if ();

  frame_rms_auto_gain uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  // Predictor state: delay store, position, frame energy, running gain.
  logic [frag_pkg::SAMPLE_W-1:0] delay_store [NFRAME];
  int unsigned         frame_pos;
  logic [63:0]         frame_energy;
  logic [31:0]         gain_run;
  // Shadow copy of the registers.
  logic                sh_enable;
  logic [31:0]         sh_target, sh_ceiling, sh_rise, sh_fall;

  frag_tb_pkg::agc_word_t expected_words[$];
  int                  errors = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;

  // Directed rows: sample and, where obvious, the expected word.
  typedef struct {
    logic signed [15:0]     smp;
    bit                     typed;
    frag_tb_pkg::agc_word_t want;
  } stim_row_t;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Move the running gain toward the level-derived target at frame end.
  task automatic adapt_gain();
    logic [63:0] ceil_v, tgt, rms, want, g, rate, stp;
    ceil_v = (sh_ceiling < 65536) ? 64'd65536 : 64'(sh_ceiling);
    tgt    = (sh_target < 1) ? 64'd1 : 64'(sh_target);
    rms    = int_sqrt((frame_energy << 16) / NFRAME);
    want   = ceil_v;
    g      = 64'(gain_run);
    if (rms > 256) want = (tgt << 24) / rms;
    if (want > ceil_v) want = ceil_v;
    if (want < 65536) want = 65536;
    rate = (want > g) ? 64'(sh_rise) : 64'(sh_fall);
    if (rate > 65536) rate = 65536;
    if (want >= g) begin
      stp = ((want - g) * rate + 32768) >> 16;
      g   = g + stp;
    end else begin
      stp = ((g - want) * rate + 32768) >> 16;
      g   = (stp >= g) ? 64'd0 : g - stp;
    end
    if (g > ceil_v) g = ceil_v;
    if (g < 65536) g = 65536;
    gain_run = g[31:0];
  endtask

  // Advance the predictor by one sample and return the word it causes.
  task automatic scale_sample(input logic [15:0] nb, output frag_tb_pkg::agc_word_t w);
    logic [15:0] ob;
    logic [63:0] mag, q;
    int          s_new, s_old;
    ob = delay_store[frame_pos];
    delay_store[frame_pos] = nb;
    s_new = $signed(nb);
    s_old = $signed(ob);
    w.out_sample   = ob;
    w.applied_gain = frag_pkg::GAIN_ONE;
    if (sh_enable && gain_run > 32'(frag_pkg::GAIN_NEAR_ONE_MAX)) begin
      mag = (s_old < 0) ? 64'(-s_old) : 64'(s_old);
      q   = (mag * gain_run + 32768) >> 16;
      if (s_old < 0) w.out_sample = (q > 32768) ? -16'sd32768 : -$signed(16'(q));
      else           w.out_sample = (q > 32767) ? 16'sd32767 : 16'(q);
      w.applied_gain = gain_run[23:0];
    end
    mag = (s_new < 0) ? 64'(-s_new) : 64'(s_new);
    frame_energy += mag * mag;
    if (frame_pos + 1 >= NFRAME) begin
      if (sh_enable) adapt_gain();
      frame_energy = 0;
      frame_pos    = 0;
    end else begin
      frame_pos++;
    end
  endtask

  // Write one register, then drop valid and leave the channel idle before returning.
  task automatic write_reg(input frag_pkg::cfg_idx_e idx, input logic [23:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      frag_pkg::REG_GAIN_ENABLE:  sh_enable  = val[0];
      frag_pkg::REG_TARGET_LEVEL: sh_target  = 32'(val[14:0]);
      frag_pkg::REG_GAIN_CEILING: sh_ceiling = 32'(val);
      frag_pkg::REG_RISE_RATE:    sh_rise    = 32'(val[16:0]);
      frag_pkg::REG_FALL_RATE:    sh_fall    = 32'(val[16:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Hold until every expected word is back, then let the frame-end math finish.
  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [15:0] smp, input bit typed,
                             input frag_tb_pkg::agc_word_t want);
    frag_tb_pkg::agc_word_t w;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.in_sample <= smp;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    scale_sample(smp, w);
    if (typed && w !== want) begin
      $display("%0t table row: expected %0d/%0d, predicted %0d/%0d", $time,
               want.out_sample, want.applied_gain, w.out_sample, w.applied_gain);
      errors++;
    end
    expected_words.push_back(w);
  endtask

  task automatic end_stream();
    in_if.valid <= 1'b0;
  endtask

  // Random sample: mostly speech-like levels of a per-frame amplitude,
  // sometimes full scale or silence.
  function automatic logic [15:0] rand_sample(input int amp);
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'($urandom);
    if (r == 1) return 16'd0;
    return 16'($signed($urandom_range(2 * amp)) - amp);
  endfunction

  task automatic random_frames(input int frames);
    int amp;
    frag_tb_pkg::agc_word_t none;
    none = '0;
    for (int f = 0; f < frames; f++) begin
      case ($urandom_range(3))
        0: amp = $urandom_range(3);
        1: amp = $urandom_range(300);
        2: amp = $urandom_range(6000);
        default: amp = 32767;
      endcase
      for (int k = 0; k < NFRAME; k++) send_sample(rand_sample(amp), 1'b0, none);
    end
    end_stream();
  endtask

  // Receiver: stall at random, compare each accepted word with the oldest one.
  always @(posedge clk_i) begin
    frag_tb_pkg::agc_word_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word: got %0d/%0d", $time,
                   out_if.out_sample, out_if.applied_gain);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (out_if.out_sample !== want.out_sample) begin
            $display("%0t out_sample: expected %0d, actual %0d", $time,
                     want.out_sample, out_if.out_sample);
            errors++;
          end
          if (out_if.applied_gain !== want.applied_gain) begin
            $display("%0t applied_gain: expected %0d, actual %0d", $time,
                     want.applied_gain, out_if.applied_gain);
            errors++;
          end
        end
      end
      out_if.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Hard stop on a hung handshake.
  initial begin
    #400ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    frag_tb_pkg::agc_word_t none;
    none = '0;
    in_if.valid     = 1'b0;
    in_if.in_sample = '0;
    out_if.ready    = 1'b1;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = frag_pkg::REG_GAIN_ENABLE;
    cfg_if.data     = '0;
    foreach (delay_store[i]) delay_store[i] = '0;
    frame_pos    = 0;
    frame_energy = 0;
    gain_run     = 65536;
    sh_enable    = 1'b0;
    sh_target    = 3000;
    sh_ceiling   = 262144;
    sh_rise      = 6554;
    sh_fall      = 6554;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first frame reads zeros from the delay store, gain one.
    r.typed = 1'b1;
    r.want  = '{out_sample: 16'sd0, applied_gain: frag_pkg::GAIN_ONE};
    r.smp = 16'sh7fff; rows.push_back(r);
    r.smp = 16'sh8000; rows.push_back(r);
    r.smp = 16'sh0001; rows.push_back(r);
    r.smp = 16'shffff; rows.push_back(r);
    r.smp = 16'sh5555; rows.push_back(r);
    r.smp = 16'shaaaa; rows.push_back(r);
    foreach (rows[i]) send_sample(rows[i].smp, rows[i].typed, rows[i].want);
    end_stream();
    drain();

    // Gain on with the fastest rise, widest ceiling: loud and quiet frames.
    write_reg(frag_pkg::REG_GAIN_ENABLE, 24'd1);
    write_reg(frag_pkg::REG_RISE_RATE, 24'd65536);
    write_reg(frag_pkg::REG_FALL_RATE, 24'd131071);
    write_reg(frag_pkg::REG_GAIN_CEILING, 24'hffffff);
    write_reg(frag_pkg::REG_TARGET_LEVEL, 24'd32767);
    for (int k = 0; k < NFRAME; k++) send_sample(16'sd4, 1'b0, none);
    for (int k = 0; k < NFRAME; k++)
      send_sample((k % 2) ? 16'sh7fff : 16'sh8000, 1'b0, none);
    end_stream();
    drain();

    // Phase: no idling, target zero, ceiling below one, zero rates.
    write_reg(frag_pkg::REG_TARGET_LEVEL, 24'd0);
    write_reg(frag_pkg::REG_GAIN_CEILING, 24'd0);
    write_reg(frag_pkg::REG_RISE_RATE, 24'd0);
    write_reg(frag_pkg::REG_FALL_RATE, 24'd0);
    random_frames(2);
    drain();

    // Sender mostly idle, typical settings.
    send_idle_pct = 88;
    write_reg(frag_pkg::REG_TARGET_LEVEL, 24'd3000);
    write_reg(frag_pkg::REG_GAIN_CEILING, 24'd262144);
    write_reg(frag_pkg::REG_RISE_RATE, 24'd6554);
    write_reg(frag_pkg::REG_FALL_RATE, 24'd20000);
    random_frames(2);
    drain();

    // Receiver stalling, random settings, then disabled with gain frozen.
    send_idle_pct  = 0;
    recv_stall_pct = 88;
    write_reg(frag_pkg::REG_TARGET_LEVEL, 24'($urandom_range(32767)));
    write_reg(frag_pkg::REG_GAIN_CEILING, 24'($urandom_range(24'hffffff, 65536)));
    write_reg(frag_pkg::REG_RISE_RATE, 24'($urandom_range(65536)));
    write_reg(frag_pkg::REG_FALL_RATE, 24'($urandom_range(65536)));
    random_frames(1);
    drain();
    write_reg(frag_pkg::REG_GAIN_ENABLE, 24'd0);
    random_frames(1);
    drain();

    // Both sides idling, enabled, lowered ceiling.
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    write_reg(frag_pkg::REG_GAIN_ENABLE, 24'd1);
    write_reg(frag_pkg::REG_GAIN_CEILING, 24'd70000);
    random_frames(2);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
